// ===== rtl/trc_pkg.sv =====
// Shared types and constants for the traceroute reply classifier.
package trc_pkg;

  // Frame layout, with a fixed 20-byte IPv4 header.
  localparam int unsigned EthHeaderBytes = 14;
  localparam int unsigned IpHeaderBytes  = 20;

  localparam int unsigned PosW = 6;
  localparam logic [PosW-1:0] POS_MAX        = '1;
  localparam logic [PosW-1:0] POS_KIND_HI    = 6'(12);
  localparam logic [PosW-1:0] POS_KIND_LO    = 6'(13);
  localparam logic [PosW-1:0] POS_PROTO      = 6'(EthHeaderBytes + 9);
  localparam logic [PosW-1:0] POS_SRC_FIRST  = 6'(EthHeaderBytes + 12);
  localparam logic [PosW-1:0] POS_SRC_LAST   = 6'(EthHeaderBytes + 15);
  localparam logic [PosW-1:0] POS_DST_FIRST  = 6'(EthHeaderBytes + 16);
  localparam logic [PosW-1:0] POS_DST_LAST   = 6'(EthHeaderBytes + 19);
  localparam logic [PosW-1:0] POS_ICMP_TYPE  = 6'(EthHeaderBytes + IpHeaderBytes);

  // Protocol code points.
  localparam logic [15:0] KIND_IPV4          = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP         = 8'd1;
  localparam logic [7:0]  ICMP_TIME_EXCEEDED = 8'd11;

  // Configuration register indexes.
  localparam int unsigned CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] CFG_TARGET_IP = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_OWN_IP    = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_IGNORED = 2'd0,
    VERDICT_HOP     = 2'd1,
    VERDICT_DEST    = 2'd2
  } verdict_t;

  // Captured summary of one finished frame.
  typedef struct packed {
    logic        is_ip;      // long enough for the ethertype, and it is IPv4
    logic        has_src;    // source address fully received
    logic        icmp_te;    // ICMP type received, ICMP protocol, time exceeded
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } frame_sum_t;

endpackage

// ===== rtl/trc_capture.sv =====
// Byte counter, header field capture and end-of-frame summary register.
module trc_capture
  import trc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_en,
  input  logic [7:0] frame_byte,
  input  logic       last_byte,
  input  logic       advance,
  output logic       sum_valid,
  output frame_sum_t sum
);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     kind_r, kind_nxt;
  logic [7:0]      proto_r, proto_nxt;
  logic [31:0]     src_r, src_nxt;
  logic [31:0]     dst_r, dst_nxt;
  logic [7:0]      mtype_r, mtype_nxt;
  logic            sum_valid_r, sum_valid_nxt;
  frame_sum_t      sum_r, sum_nxt;

  // Field values with the current beat merged in.
  always_comb begin
    kind_nxt  = kind_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    mtype_nxt = mtype_r;
    if (pos_r == POS_KIND_HI || pos_r == POS_KIND_LO) begin
      kind_nxt = {kind_r[7:0], frame_byte};
    end else if (pos_r == POS_PROTO) begin
      proto_nxt = frame_byte;
    end else if (pos_r >= POS_SRC_FIRST && pos_r <= POS_SRC_LAST) begin
      src_nxt = {src_r[23:0], frame_byte};
    end else if (pos_r >= POS_DST_FIRST && pos_r <= POS_DST_LAST) begin
      dst_nxt = {dst_r[23:0], frame_byte};
    end else if (pos_r == POS_ICMP_TYPE) begin
      mtype_nxt = frame_byte;
    end
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  end

  // Summary of the frame as it stands after this beat.
  always_comb begin
    sum_nxt.is_ip    = (pos_r >= POS_KIND_LO) && (kind_nxt == KIND_IPV4);
    sum_nxt.has_src  = (pos_r >= POS_SRC_LAST);
    sum_nxt.icmp_te  = (pos_r >= POS_ICMP_TYPE) && (proto_nxt == PROTO_ICMP) &&
                       (mtype_nxt == ICMP_TIME_EXCEEDED);
    sum_nxt.src_addr = src_nxt;
    sum_nxt.dst_addr = dst_nxt;
  end

  // The summary slot fills on a last beat and empties when the result stage takes it.
  always_comb begin
    sum_valid_nxt = sum_valid_r;
    if (advance) begin
      sum_valid_nxt = 1'b0;
    end
    if (beat_en && last_byte) begin
      sum_valid_nxt = 1'b1;
    end
  end

  // Capture state, cleared at every frame end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      kind_r      <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      mtype_r     <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= sum_valid_nxt;
      if (beat_en) begin
        if (last_byte) begin
          pos_r   <= '0;
          kind_r  <= '0;
          proto_r <= '0;
          src_r   <= '0;
          dst_r   <= '0;
          mtype_r <= '0;
        end else begin
          pos_r   <= pos_nxt;
          kind_r  <= kind_nxt;
          proto_r <= proto_nxt;
          src_r   <= src_nxt;
          dst_r   <= dst_nxt;
          mtype_r <= mtype_nxt;
        end
      end
    end
  end

  // Summary payload needs no reset.
  always_ff @(posedge clk) begin
    if (beat_en && last_byte) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum       = sum_r;

endmodule

// ===== rtl/trc_classify.sv =====
// Address compares, verdict selection and the result register.
module trc_classify
  import trc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        sum_valid,
  input  frame_sum_t  sum,
  input  logic [31:0] target_ip,
  input  logic [31:0] own_ip,
  input  logic        out_stall,
  output logic        advance,
  output logic        out_valid,
  output verdict_t    out_verdict,
  output logic [31:0] out_responder_ip
);

  logic        out_valid_r;
  verdict_t    verdict_r, verdict_nxt;
  logic [31:0] resp_r, resp_nxt;

  // The result register can load when it is empty or being taken.
  assign advance = sum_valid && (!out_valid_r || !out_stall);

  // Destination test wins over the hop test.
  always_comb begin
    verdict_nxt = VERDICT_IGNORED;
    if (sum.is_ip && sum.has_src && (sum.src_addr == target_ip)) begin
      verdict_nxt = VERDICT_DEST;
    end else if (sum.is_ip && sum.icmp_te && (sum.dst_addr == own_ip)) begin
      verdict_nxt = VERDICT_HOP;
    end
    resp_nxt = (verdict_nxt == VERDICT_IGNORED) ? '0 : sum.src_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict_r <= verdict_nxt;
      resp_r    <= resp_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_responder_ip = resp_r;

endmodule

// ===== rtl/traceroute_reply_classifier.sv =====
// Top level of the traceroute reply classifier: ports, configuration and checks.
//
//   Channel | Direction | Handshake         | Payload
//   in      | input     | in_valid/in_stall | in_frame_byte[7:0], in_last_byte
//   out     | output    | out_valid/stall   | out_verdict[1:0], out_responder_ip[31:0]
//   cfg     | input     | cfg_wr_en         | cfg_index[0], cfg_data[31:0]
//
// One frame byte is taken per cycle while in_stall is low; a byte that is not
// the last gives no result. A last byte loads a frame summary register, and the
// verdict then passes into the result register once that register is free.
// in_stall rises only when a summary waits and the result register is held by
// out_stall. Reset is synchronous; it clears all but the summary and result data.
module traceroute_reply_classifier
  import trc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_frame_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_verdict,
  output logic [31:0]          out_responder_ip,
  input  logic                 cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] target_addr_r;
  logic [31:0] own_addr_r;
  logic        beat_en;
  logic        advance;
  logic        sum_valid;
  frame_sum_t  sum;
  verdict_t    verdict;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_addr_r <= '0;
      own_addr_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TARGET_IP: target_addr_r <= cfg_data;
        CFG_OWN_IP:    own_addr_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Input beat handshake.
  assign in_stall = sum_valid && !advance;
  assign beat_en  = in_valid && !in_stall;

  trc_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_en    (beat_en),
    .frame_byte (in_frame_byte),
    .last_byte  (in_last_byte),
    .advance    (advance),
    .sum_valid  (sum_valid),
    .sum        (sum)
  );

  trc_classify u_classify (
    .clk              (clk),
    .rst_n            (rst_n),
    .sum_valid        (sum_valid),
    .sum              (sum),
    .target_ip        (target_addr_r),
    .own_ip           (own_addr_r),
    .out_stall        (out_stall),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_verdict      (verdict),
    .out_responder_ip (out_responder_ip)
  );

  assign out_verdict = verdict;

  // An ignored frame reports no responder.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (verdict == VERDICT_IGNORED) |-> out_responder_ip == '0)
    else $error("ignored frame carries a responder address");

  // The input stalls only while a frame summary is waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> sum_valid && out_valid && out_stall)
    else $error("input stalled without a waiting summary");

  // A last beat always leaves a summary behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    beat_en && in_last_byte |=> sum_valid)
    else $error("last beat did not load a frame summary");

  // A summary taken by the result stage shows up as a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("summary lost on its way to the result register");

endmodule

// ===== sim/trc_checker.sv =====
// Checker for the traceroute reply classifier: predicts each verdict and compares the results.
module trc_checker
  import trc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_frame_byte,
  input  logic                 in_last_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_verdict,
  input  logic [31:0]          out_responder_ip,
  input  logic                 cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatches,
  output int                   awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    verdict_t    verdict;
    logic [31:0] responder;
  } reply_t;

  reply_t expected_replies[$];

  // Configuration as the block should see it.
  logic [31:0] target_ip;
  logic [31:0] own_ip;

  // Fields captured from the frame in progress.
  logic [PosW-1:0] frame_pos;
  logic [15:0]     ether_kind;
  logic [7:0]      ip_proto;
  logic [31:0]     src_addr;
  logic [31:0]     dst_addr;
  logic [7:0]      msg_type;

  function automatic void clear_frame();
    frame_pos  = '0;
    ether_kind = '0;
    ip_proto   = '0;
    src_addr   = '0;
    dst_addr   = '0;
    msg_type   = '0;
  endfunction

  // Captures one frame byte and, on the last byte, queues the verdict it implies.
  function automatic void classify_beat(input logic [7:0] b, input logic last);
    int     len;
    logic   is_ip;
    reply_t r;
    if (frame_pos == POS_KIND_HI || frame_pos == POS_KIND_LO) begin
      ether_kind = {ether_kind[7:0], b};
    end else if (frame_pos == POS_PROTO) begin
      ip_proto = b;
    end else if (frame_pos >= POS_SRC_FIRST && frame_pos <= POS_SRC_LAST) begin
      src_addr = {src_addr[23:0], b};
    end else if (frame_pos >= POS_DST_FIRST && frame_pos <= POS_DST_LAST) begin
      dst_addr = {dst_addr[23:0], b};
    end else if (frame_pos == POS_ICMP_TYPE) begin
      msg_type = b;
    end
    len = int'(frame_pos) + 1;
    if (frame_pos != POS_MAX) begin
      frame_pos = frame_pos + 1'b1;
    end
    if (last) begin
      is_ip = (len >= int'(EthHeaderBytes)) && (ether_kind == KIND_IPV4);
      r.verdict   = VERDICT_IGNORED;
      r.responder = '0;
      // The destination test takes priority over the hop test.
      if (is_ip && len >= int'(EthHeaderBytes) + 16 && src_addr == target_ip) begin
        r.verdict = VERDICT_DEST;
      end else if (is_ip && len >= int'(EthHeaderBytes + IpHeaderBytes) + 1 &&
                   ip_proto == PROTO_ICMP && msg_type == ICMP_TIME_EXCEEDED &&
                   dst_addr == own_ip) begin
        r.verdict = VERDICT_HOP;
      end
      if (r.verdict != VERDICT_IGNORED) begin
        r.responder = src_addr;
      end
      expected_replies.push_back(r);
      clear_frame();
    end
  endfunction

  // Watch all three ports on the rising edge.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      target_ip  = '0;
      own_ip     = '0;
      mismatches = 0;
      clear_frame();
      expected_replies.delete();
      awaiting <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TARGET_IP: target_ip = cfg_data;
          CFG_OWN_IP:    own_ip    = cfg_data;
          default: ;
        endcase
      end
      // Compare an outgoing beat before queuing anything from this edge.
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t trc_checker: unexpected result, verdict %0d responder %h",
                   $time, out_verdict, out_responder_ip);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (out_verdict !== want.verdict) begin
            $display("%0t trc_checker: verdict expected %0d actual %0d",
                     $time, want.verdict, out_verdict);
            mismatches++;
          end
          if (out_responder_ip !== want.responder) begin
            $display("%0t trc_checker: responder expected %h actual %h",
                     $time, want.responder, out_responder_ip);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        classify_beat(in_frame_byte, in_last_byte);
      end
      awaiting <= expected_replies.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the traceroute reply classifier: clock, reset, stimulus and verdict.
module tb
  import trc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_HEAVY} stall_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_frame_byte;
  logic                 in_last_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_verdict;
  logic [31:0]          out_responder_ip;
  logic                 cfg_wr_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   mismatches;
  int                   awaiting;

  // Stimulus state.
  logic [7:0]  frame_bytes[$];
  logic [31:0] target_now;
  logic [31:0] own_now;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  int          bytes_sent = 0;

  // Receiver stall pattern state.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        stall_hold = 1'b0;

  traceroute_reply_classifier u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_byte    (in_frame_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_responder_ip (out_responder_ip),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  trc_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_byte    (in_frame_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_responder_ip (out_responder_ip),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .awaiting         (awaiting)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver stalls follow a randomly chosen mode: none, coin toss, runs or heavy.
  always @(negedge clk) begin
    logic stall_now;
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: stall_now = 1'b0;
      STALL_COIN: stall_now = 1'($urandom_range(0, 1));
      STALL_RUNS: begin
        if (run_left == 0) begin
          stall_hold = !stall_hold;
          run_left   = $urandom_range(1, 24);
        end
        run_left--;
        stall_now = stall_hold;
      end
      default: stall_now = ($urandom_range(0, 3) != 0);
    endcase
    out_stall <= stall_now;
  end

  // Sends one beat, sometimes with a random idle gap at the start of a burst.
  task automatic send_beat(input logic [7:0] b, input logic last);
    int idle;
    idle = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_gaps && $urandom_range(0, 3) != 0) begin
        idle = $urandom_range(1, 6);
      end
    end
    burst_left--;
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_last_byte  <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Holds the sender off until every pending verdict has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_addresses(input logic [31:0] target, input logic [31:0] own);
    settle();
    write_reg(CFG_TARGET_IP, target);
    write_reg(CFG_OWN_IP, own);
    target_now = target;
    own_now    = own;
  endtask

  // Builds a frame of random bytes with the header fields placed at their offsets.
  task automatic build_frame(input int len, input logic [15:0] kind, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [7:0] mtype);
    logic [7:0] b;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == int'(POS_KIND_HI)) b = kind[15:8];
      else if (i == int'(POS_KIND_LO)) b = kind[7:0];
      else if (i == int'(POS_PROTO)) b = proto;
      else if (i >= int'(POS_SRC_FIRST) && i <= int'(POS_SRC_LAST))
        b = src[8*(int'(POS_SRC_LAST) - i) +: 8];
      else if (i >= int'(POS_DST_FIRST) && i <= int'(POS_DST_LAST))
        b = dst[8*(int'(POS_DST_LAST) - i) +: 8];
      else if (i == int'(POS_ICMP_TYPE)) b = mtype;
      frame_bytes.push_back(b);
    end
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic send_built(input int len, input logic [15:0] kind, input logic [7:0] proto,
                            input logic [31:0] src, input logic [31:0] dst,
                            input logic [7:0] mtype);
    build_frame(len, kind, proto, src, dst, mtype);
    send_frame();
  endtask

  // Mostly well-formed replies, with near misses, short frames and noise mixed in.
  task automatic random_frame();
    int          shape;
    int          len;
    int          pick;
    logic [15:0] kind;
    logic [7:0]  proto;
    logic [7:0]  mtype;
    logic [31:0] src;
    logic [31:0] dst;
    shape = $urandom_range(0, 99);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(46, 90) : $urandom_range(35, 45);
    kind  = KIND_IPV4;
    proto = 8'($urandom);
    mtype = 8'($urandom);
    src   = $urandom;
    dst   = $urandom;
    if (shape < 35) begin
      src = target_now;
    end else if (shape < 90) begin
      proto = PROTO_ICMP;
      mtype = ICMP_TIME_EXCEEDED;
      dst   = own_now;
      if ($urandom_range(0, 4) == 0) src = target_now;
    end
    if (shape >= 65 && shape < 80) begin
      // Near miss: one bit off in one field.
      pick = $urandom_range(0, 4);
      case (pick)
        0: kind[$urandom_range(0, 15)] ^= 1'b1;
        1: proto[$urandom_range(0, 7)] ^= 1'b1;
        2: mtype[$urandom_range(0, 7)] ^= 1'b1;
        3: dst[$urandom_range(0, 31)] ^= 1'b1;
        default: src = target_now ^ (32'h1 << $urandom_range(0, 31));
      endcase
    end else if (shape >= 80 && shape < 90) begin
      // Short frame, often right at a field boundary.
      if (shape < 85) src = target_now;
      pick = $urandom_range(0, 7);
      case (pick)
        0: len = 13;
        1: len = 14;
        2: len = 29;
        3: len = 30;
        4: len = 34;
        5: len = 35;
        default: len = $urandom_range(1, 35);
      endcase
    end else if (shape >= 90) begin
      len = $urandom_range(1, 70);
      if ($urandom_range(0, 1) == 0) kind = 16'($urandom);
    end
    send_built(len, kind, proto, src, dst, mtype);
  endtask

  // Overall time limit.
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int          phase_start;
    int          frames;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_frame_byte = '0;
    in_last_byte  = 1'b0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_TARGET_IP;
    cfg_data      = '0;
    target_now    = '0;
    own_now       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset addresses.
    send_built(1, KIND_IPV4, PROTO_ICMP, 32'h0, 32'h0, ICMP_TIME_EXCEEDED);
    send_built(13, KIND_IPV4, PROTO_ICMP, target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(29, KIND_IPV4, 8'($urandom), target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(30, KIND_IPV4, 8'($urandom), target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(34, KIND_IPV4, PROTO_ICMP, ~target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(35, KIND_IPV4, PROTO_ICMP, ~target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(35, KIND_IPV4, PROTO_ICMP, target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(100, KIND_IPV4, PROTO_ICMP, 32'hC0A8_0101, own_now, ICMP_TIME_EXCEEDED);
    send_built(40, ~KIND_IPV4, PROTO_ICMP, target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(40, KIND_IPV4, ~PROTO_ICMP, ~target_now, own_now, ICMP_TIME_EXCEEDED);
    send_built(40, KIND_IPV4, PROTO_ICMP, ~target_now, own_now, ~ICMP_TIME_EXCEEDED);
    send_built(40, KIND_IPV4, PROTO_ICMP, ~target_now, ~own_now, ICMP_TIME_EXCEEDED);

    // Directed frames with both addresses at the top of their range.
    set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_built(40, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_built(40, KIND_IPV4, 8'h00, 32'hFFFF_FFFF, 32'h0, 8'h00);
    send_built(40, KIND_IPV4, PROTO_ICMP, 32'h0, 32'hFFFF_FFFF, ICMP_TIME_EXCEEDED);

    // Random phases, each under its own address setting.
    for (int phase = 0; phase < 6; phase++) begin
      addr_a = $urandom;
      addr_b = $urandom;
      case (phase)
        0: set_addresses(32'h0, 32'hFFFF_FFFF);
        1: set_addresses(32'hFFFF_FFFF, 32'h0);
        3: set_addresses(addr_a, addr_a);
        5: set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_addresses(addr_a, addr_b);
      endcase
      // One phase runs the sender flat out.
      sender_gaps = (phase != 2);
      phase_start = bytes_sent;
      frames = 0;
      while (bytes_sent - phase_start < 100 || frames < 2) begin
        random_frame();
        frames++;
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
